// ===== sv/text_console_writer_core_macros.svh =====
// Assertion macros used by the console writer sequencer.
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define TCW_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ===== sv/tcw_pkg.sv =====
// Shared constants and types of the text console writer.
`default_nettype none
package tcw_pkg;

  localparam int COLS     = 80;
  localparam int ROWS     = 25;
  localparam int CELLS    = COLS * ROWS;

  localparam int OP_W     = 2;
  localparam int CHAR_W   = 8;
  localparam int CURSOR_W = 11;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int ROW_W    = $clog2(ROWS + 1);
  localparam int COL_W    = $clog2(COLS);

  localparam logic [CHAR_W-1:0] BLANK = 8'h20;

  localparam logic [OP_W-1:0] OP_PUT     = 2'd0;
  localparam logic [OP_W-1:0] OP_NEWLINE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;
  localparam logic [OP_W-1:0] OP_READ    = 2'd3;

  localparam logic [CURSOR_W-1:0] CELLS_C     = CURSOR_W'(CELLS);
  localparam logic [CURSOR_W-1:0] LAST_CELL_C = CURSOR_W'(CELLS - 1);
  localparam logic [CURSOR_W-1:0] LAST_BASE_C = CURSOR_W'(CELLS - COLS);
  localparam logic [CURSOR_W-1:0] COLS_C      = CURSOR_W'(COLS);

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_cell;
    logic [CHAR_W-1:0]   read_char;
    logic                scrolled;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/tcw_if.sv =====
// Valid/ready channel interfaces for console commands and results.
`default_nettype none
interface tcw_in_if import tcw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [CHAR_W-1:0]   char_code;
  logic [CURSOR_W-1:0] cell_index;

  modport source (output valid, output op, output char_code, output cell_index, input ready);
  modport sink   (input valid, input op, input char_code, input cell_index, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CURSOR_W-1:0] cursor_cell;
  logic [CHAR_W-1:0]   read_char;
  logic                scrolled;

  modport source (output valid, output cursor_cell, output read_char, output scrolled,
                  input ready);
  modport sink   (input valid, input cursor_cell, input read_char, input scrolled,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/tcw_screen_ram.sv =====
// Character memory of the screen: one write port, one registered read port.
`default_nettype none
module tcw_screen_ram import tcw_pkg::*; (
  input  wire logic              clk,
  input  wire ram_req_t          req,
  output logic [CHAR_W-1:0]      rdata
);

  logic [CHAR_W-1:0] mem [CELLS];
  logic [CHAR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== sv/tcw_sequencer.sv =====
// Command sequencer: cursor tracking, clear sweep and scroll copy over the screen memory.
`default_nettype none
`include "text_console_writer_core_macros.svh"
module tcw_sequencer import tcw_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [OP_W-1:0]     in_op,
  input  wire logic [CHAR_W-1:0]   in_char,
  input  wire logic [CURSOR_W-1:0] in_idx,
  output logic                     in_ready,
  input  wire logic                res_free,
  output logic                     res_valid,
  output result_t                  res,
  output ram_req_t                 ram_req,
  input  wire logic [CHAR_W-1:0]   ram_rdata
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_CLEAR  = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_PUTW   = 3'd4;
  localparam logic [2:0] ST_READ   = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [CURSOR_W-1:0] cnt_r, cnt_nxt;
  logic [CURSOR_W-1:0] rptr_r, rptr_nxt;
  logic [CURSOR_W-1:0] last_r, last_nxt;
  logic [CURSOR_W-1:0] lim_r, lim_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [CHAR_W-1:0]   char_r, char_nxt;
  logic                rd_ok_r, rd_ok_nxt;
  logic [CURSOR_W-1:0] cursor_r, cursor_nxt;
  logic [CURSOR_W-1:0] rowbase_r, rowbase_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic                in_fire;
  logic                scrolled;
  logic [CHAR_W-1:0]   read_char;
  logic [CURSOR_W-1:0] nl_last;

  assign in_ready = (state_r == ST_IDLE) && res_free;
  assign in_fire  = in_valid && in_ready;
  assign nl_last  = (cursor_r > LAST_CELL_C) ? LAST_CELL_C : cursor_r;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    rptr_nxt    = rptr_r;
    last_nxt    = last_r;
    lim_nxt     = lim_r;
    op_nxt      = op_r;
    char_nxt    = char_r;
    rd_ok_nxt   = rd_ok_r;
    cursor_nxt  = cursor_r;
    rowbase_nxt = rowbase_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    ram_req     = '0;
    res_valid   = 1'b0;
    scrolled    = 1'b0;
    read_char   = '0;

    case (state_r)
      ST_INIT, ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = ADDR_W'(cnt_r);
        ram_req.wdata = BLANK;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == LAST_CELL_C) begin
          state_nxt = ST_IDLE;
          res_valid = (state_r == ST_CLEAR);
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          op_nxt   = in_op;
          char_nxt = in_char;
          case (in_op)
            OP_PUT: begin
              if (cursor_r == CELLS_C) begin
                // The screen is full: scroll first, then write on the last row.
                last_nxt      = LAST_CELL_C;
                lim_nxt       = LAST_CELL_C - COLS_C;
                cnt_nxt       = '0;
                rptr_nxt      = CURSOR_W'(COLS + 1);
                ram_req.raddr = ADDR_W'(COLS);
                state_nxt     = ST_SCROLL;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = ADDR_W'(cursor_r);
                ram_req.wdata = in_char;
                cursor_nxt    = cursor_r + 1'b1;
                if (col_r == COL_W'(COLS - 1)) begin
                  col_nxt     = '0;
                  row_nxt     = row_r + 1'b1;
                  rowbase_nxt = rowbase_r + COLS_C;
                end else begin
                  col_nxt = col_r + 1'b1;
                end
                res_valid = 1'b1;
              end
            end
            OP_NEWLINE: begin
              if (row_r >= ROW_W'(ROWS - 1)) begin
                last_nxt      = nl_last;
                lim_nxt       = nl_last - COLS_C;
                cnt_nxt       = '0;
                rptr_nxt      = CURSOR_W'(COLS + 1);
                ram_req.raddr = ADDR_W'(COLS);
                state_nxt     = ST_SCROLL;
              end else begin
                cursor_nxt  = rowbase_r + COLS_C;
                rowbase_nxt = rowbase_r + COLS_C;
                row_nxt     = row_r + 1'b1;
                col_nxt     = '0;
                res_valid   = 1'b1;
              end
            end
            OP_CLEAR: begin
              cnt_nxt     = '0;
              cursor_nxt  = '0;
              rowbase_nxt = '0;
              row_nxt     = '0;
              col_nxt     = '0;
              state_nxt   = ST_CLEAR;
            end
            default: begin
              rd_ok_nxt     = (in_idx < CELLS_C);
              ram_req.raddr = (in_idx < CELLS_C) ? ADDR_W'(in_idx) : '0;
              state_nxt     = ST_READ;
            end
          endcase
        end
      end

      ST_SCROLL: begin
        // Cell cnt takes the cell one row below while that one is still inside the
        // copied range; the vacated tail of the range below the first row turns blank.
        if (cnt_r <= lim_r) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = ADDR_W'(cnt_r);
          ram_req.wdata = ram_rdata;
        end else if (cnt_r >= COLS_C) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = ADDR_W'(cnt_r);
          ram_req.wdata = BLANK;
        end
        ram_req.raddr = (rptr_r < CELLS_C) ? ADDR_W'(rptr_r) : '0;
        cnt_nxt       = cnt_r + 1'b1;
        rptr_nxt      = rptr_r + 1'b1;
        if (cnt_r == last_r) begin
          if (op_r == OP_PUT) begin
            state_nxt = ST_PUTW;
          end else begin
            cursor_nxt  = LAST_BASE_C;
            rowbase_nxt = LAST_BASE_C;
            row_nxt     = ROW_W'(ROWS - 1);
            col_nxt     = '0;
            scrolled    = 1'b1;
            res_valid   = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end
      end

      ST_PUTW: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = ADDR_W'(LAST_BASE_C);
        ram_req.wdata = char_r;
        cursor_nxt    = LAST_BASE_C + 1'b1;
        rowbase_nxt   = LAST_BASE_C;
        row_nxt       = ROW_W'(ROWS - 1);
        col_nxt       = COL_W'(1);
        scrolled      = 1'b1;
        res_valid     = 1'b1;
        state_nxt     = ST_IDLE;
      end

      ST_READ: begin
        read_char = rd_ok_r ? ram_rdata : '0;
        res_valid = 1'b1;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_INIT;
        cnt_nxt   = '0;
      end
    endcase
  end

  assign res.cursor_cell = cursor_nxt;
  assign res.read_char   = read_char;
  assign res.scrolled    = scrolled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_INIT;
      cnt_r     <= '0;
      cursor_r  <= '0;
      rowbase_r <= '0;
      row_r     <= '0;
      col_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      cursor_r  <= cursor_nxt;
      rowbase_r <= rowbase_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rptr_r  <= rptr_nxt;
    last_r  <= last_nxt;
    lim_r   <= lim_nxt;
    op_r    <= op_nxt;
    char_r  <= char_nxt;
    rd_ok_r <= rd_ok_nxt;
  end

  `TCW_ASSERT(a_cursor_range, cursor_r <= CELLS_C, "cursor beyond the end of the screen")
  `TCW_ASSERT(a_cursor_split, cursor_r == rowbase_r + CURSOR_W'(col_r), "cursor out of step with row and column")
  `TCW_ASSERT(a_res_room, res_valid |-> res_free, "result produced while the output register is full")
  `TCW_ASSERT(a_scroll_bound, (state_r == ST_SCROLL && ram_req.we) |-> ram_req.waddr <= ADDR_W'(last_r), "scroll wrote past the cursor cell")
  `TCW_ASSERT_NEXT(a_clear_start, in_fire && in_op == OP_CLEAR, state_r == ST_CLEAR && cursor_r == '0, "clear did not start the sweep")

endmodule
`default_nettype wire

// ===== sv/text_console_writer_core.sv =====
// Top level of the text console writer: sequencer, screen memory and result register.
//
// Commands arrive on in_ch (op, char_code, cell_index) and each one produces exactly
// one beat on out_ch (cursor_cell, read_char, scrolled). Both are valid/ready channels;
// a beat moves at a rising edge with valid and ready high.
// Path of each command from the accepting edge to the result being valid:
//   put that does not scroll, newline that does not scroll: result registered at that edge;
//   read: one registered memory read, then the result;
//   clear: one blank write per cell, the result with the last one;
//   newline or put that scrolls: one cell copied per cycle through the single write port
//   up to the cursor cell, and for a put then the character write on the last row.
// The block takes one command at a time; in_ch.ready is high only while the sequencer
// is idle and the result register is empty or being emptied in that cycle.
// After reset the screen memory is swept to blanks, all CELLS cells (2000 at 80 by 25),
// and in_ch.ready stays low meanwhile; the cursor starts at cell zero.
// A stalled receiver holds the result in the output register, and no new command is
// taken until that beat has gone.
`default_nettype none
module text_console_writer_core import tcw_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  tcw_in_if.sink    in_ch,
  tcw_out_if.source out_ch
);

  ram_req_t          ram_req;
  logic [CHAR_W-1:0] ram_rdata;
  logic              res_valid;
  result_t           res;
  logic              res_free;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_r;

  assign res_free = !out_valid_r || out_ch.ready;

  tcw_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_char   (in_ch.char_code),
    .in_idx    (in_ch.cell_index),
    .in_ready  (in_ch.ready),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  tcw_screen_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.cursor_cell = out_r.cursor_cell;
  assign out_ch.read_char   = out_r.read_char;
  assign out_ch.scrolled    = out_r.scrolled;

endmodule
`default_nettype wire

// ===== bench/text_console_writer_core_tb.sv =====
// Self-checking testbench for text_console_writer_core: random console commands and a screen model.
`default_nettype none
module text_console_writer_core_tb import tcw_pkg::*; ();

  localparam int IDLE_LIMIT = 20000;
  localparam int CMD_TARGET = 300;

  typedef struct {
    logic [OP_W-1:0]     op;
    logic [CHAR_W-1:0]   char_code;
    logic [CURSOR_W-1:0] cell_index;
  } console_cmd_t;

  logic clk;
  logic rst_n;

  tcw_in_if  in_if();
  tcw_out_if out_if();

  text_console_writer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  console_cmd_t pending_cmds[$];
  result_t      expected_results[$];
  console_cmd_t next_cmd;

  logic [CHAR_W-1:0]   screen_model [0:CELLS-1];
  logic [CURSOR_W-1:0] cursor_model;

  int err_count;
  int idle_cycles;
  int send_gap;
  int stall_left;
  bit in_beat_taken;
  bit no_idle_stretch;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one, and stretches with none at all.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle_stretch || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Rows from the second one up to the cursor cell move up one row; sources become blanks.
  task automatic scroll_model_up();
    int last;
    last = (cursor_model > CELLS - 1) ? CELLS - 1 : int'(cursor_model);
    for (int i = COLS; i <= last; i++) begin
      screen_model[i - COLS] = screen_model[i];
      screen_model[i] = BLANK;
    end
  endtask

  task automatic predict_console_step(input console_cmd_t cmd, output result_t res);
    int row;
    res.read_char = '0;
    res.scrolled = 1'b0;
    if (cursor_model > CELLS) cursor_model = CELLS_C;
    case (cmd.op)
      OP_PUT: begin
        // A put past the last cell scrolls first and lands on the last row.
        if (cursor_model >= CELLS) begin
          scroll_model_up();
          cursor_model = cursor_model - COLS_C;
          res.scrolled = 1'b1;
        end
        screen_model[cursor_model] = cmd.char_code;
        cursor_model = cursor_model + 1'b1;
      end
      OP_NEWLINE: begin
        row = cursor_model / COLS;
        if (row > ROWS - 1) row = ROWS - 1;
        row++;
        if (row > ROWS - 1) begin
          scroll_model_up();
          row--;
          res.scrolled = 1'b1;
        end
        cursor_model = CURSOR_W'(row * COLS);
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK;
        cursor_model = '0;
      end
      default: begin
        if (cmd.cell_index < CELLS) res.read_char = screen_model[cmd.cell_index];
      end
    endcase
    res.cursor_cell = cursor_model;
  endtask

  task automatic push_cmd(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                          input logic [CURSOR_W-1:0] idx);
    console_cmd_t cmd;
    cmd.op = op;
    cmd.char_code = ch;
    cmd.cell_index = idx;
    pending_cmds.push_back(cmd);
  endtask

  task automatic push_text_run(input int n);
    for (int i = 0; i < n; i++)
      push_cmd(OP_PUT, CHAR_W'($urandom_range(0, 255)), CURSOR_W'($urandom_range(0, 2047)));
  endtask

  task automatic push_random_read();
    if ($urandom_range(0, 4) == 0)
      push_cmd(OP_READ, CHAR_W'($urandom()), CURSOR_W'($urandom_range(CELLS, 2047)));
    else
      push_cmd(OP_READ, CHAR_W'($urandom()), CURSOR_W'($urandom_range(0, CELLS - 1)));
  endtask

  task automatic push_random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) push_text_run(1);
    else if (r < 65) push_cmd(OP_NEWLINE, CHAR_W'($urandom()), CURSOR_W'($urandom()));
    else if (r < 96) push_random_read();
    else push_cmd(OP_CLEAR, CHAR_W'($urandom()), CURSOR_W'($urandom()));
  endtask

  initial begin
    int r;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = OP_PUT;
    in_if.char_code = '0;
    in_if.cell_index = '0;
    out_if.ready = 1'b0;
    err_count = 0;
    send_gap = 0;
    stall_left = 0;
    in_beat_taken = 1'b0;
    no_idle_stretch = 1'b0;
    cursor_model = '0;
    for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK;

    // Reads of a fresh screen, including both ends and addresses past the last cell, then puts, newlines and a clear.
    push_cmd(OP_READ, 8'h00, 11'd0);
    push_cmd(OP_READ, 8'hFF, 11'd1999);
    push_cmd(OP_READ, 8'h00, 11'd2000);
    push_cmd(OP_READ, 8'h00, 11'd2047);
    push_cmd(OP_PUT, 8'h00, 11'd0);
    push_cmd(OP_PUT, 8'hFF, 11'd2047);
    push_cmd(OP_PUT, 8'h41, 11'd0);
    push_cmd(OP_READ, 8'h00, 11'd0);
    push_cmd(OP_READ, 8'h00, 11'd1);
    push_cmd(OP_READ, 8'h00, 11'd2);
    push_cmd(OP_NEWLINE, 8'h00, 11'd0);
    push_cmd(OP_PUT, 8'h55, 11'd0);
    push_cmd(OP_READ, 8'h00, 11'd80);
    push_cmd(OP_CLEAR, 8'hFF, 11'd2047);
    push_cmd(OP_READ, 8'h00, 11'd0);
    push_cmd(OP_READ, 8'h00, 11'd80);
    push_cmd(OP_NEWLINE, 8'h00, 11'd0);
    push_cmd(OP_NEWLINE, 8'h00, 11'd0);
    push_cmd(OP_PUT, 8'hAA, 11'd0);

    // Walk down to the last row, fill it, then newline and put with the cursor at screen end.
    repeat (24) push_cmd(OP_NEWLINE, 8'h00, 11'd0);
    push_text_run(80);
    push_cmd(OP_READ, 8'h00, 11'd1999);
    push_cmd(OP_NEWLINE, 8'h00, 11'd0);
    push_cmd(OP_READ, 8'h00, 11'd1919);
    push_text_run(81);
    push_cmd(OP_READ, 8'h00, 11'd1999);
    push_cmd(OP_READ, 8'h00, 11'd1840);

    while (pending_cmds.size() < CMD_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        push_random_op();
      end else if (r < 85) begin
        push_text_run($urandom_range(1, 81));
        if ($urandom_range(0, 1)) push_cmd(OP_NEWLINE, 8'h00, CURSOR_W'($urandom()));
      end else begin
        repeat ($urandom_range(2, 4)) push_random_read();
      end
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // The queue and valid only change at the falling edge, so they are stable here.
    while (pending_cmds.size() > 0 || in_if.valid) @(posedge clk);
    while (expected_results.size() > 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) $display("text_console_writer_core_tb: clean");
    else $display("text_console_writer_core_tb: errors");
    $finish;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_if.valid || in_beat_taken) begin
        if (send_gap > 0) begin
          in_if.valid <= 1'b0;
          send_gap = send_gap - 1;
        end else if (pending_cmds.size() > 0) begin
          next_cmd = pending_cmds.pop_front();
          in_if.op <= next_cmd.op;
          in_if.char_code <= next_cmd.char_code;
          in_if.cell_index <= next_cmd.cell_index;
          in_if.valid <= 1'b1;
          send_gap = pick_gap();
          if ($urandom_range(0, 99) < 4) no_idle_stretch = !no_idle_stretch;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Results are checked before the command taken at the same edge is predicted.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got.cursor_cell = out_if.cursor_cell;
        got.read_char = out_if.read_char;
        got.scrolled = out_if.scrolled;
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result beat: cursor_cell %0d read_char %0h scrolled %0b",
                   $time, got.cursor_cell, got.read_char, got.scrolled);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.cursor_cell !== want.cursor_cell) begin
            $display("%0t cursor_cell mismatch: expected %0d actual %0d",
                     $time, want.cursor_cell, got.cursor_cell);
            err_count++;
          end
          if (got.read_char !== want.read_char) begin
            $display("%0t read_char mismatch: expected %0h actual %0h",
                     $time, want.read_char, got.read_char);
            err_count++;
          end
          if (got.scrolled !== want.scrolled) begin
            $display("%0t scrolled mismatch: expected %0b actual %0b",
                     $time, want.scrolled, got.scrolled);
            err_count++;
          end
        end
      end
      in_beat_taken = in_if.valid && in_if.ready;
      if (in_beat_taken) begin
        next_cmd.op = in_if.op;
        next_cmd.char_code = in_if.char_code;
        next_cmd.cell_index = in_if.cell_index;
        predict_console_step(next_cmd, want);
        expected_results.push_back(want);
      end
    end
  end

  // The limit covers the blanking sweep after reset and a full-screen scroll under a stall.
  always @(posedge clk) begin
    if (rst_n && !(in_if.valid && in_if.ready) && !(out_if.valid && out_if.ready))
      idle_cycles++;
    else
      idle_cycles = 0;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("text_console_writer_core_tb: errors");
      $finish;
    end
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/tcw_pkg.sv
sv/tcw_if.sv
sv/tcw_screen_ram.sv
sv/tcw_sequencer.sv
sv/text_console_writer_core.sv
bench/text_console_writer_core_tb.sv
